// ===== rtl/lef_pkg.sv =====
// Shared types, sizes and the per-channel Laplacian kernel for the 3x3 edge filter.
// Used by the result FIFO and the top level; depends on nothing else.
package lef_pkg;

  // Frame limits and coordinate widths.
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int X_W        = $clog2(MAX_WIDTH);
  localparam int Y_W        = $clog2(MAX_HEIGHT);
  localparam int SIZE_W     = 11;
  localparam int PIX_W      = 24;

  // Results per input pixel and result queue sizing.
  localparam int MAX_RES    = 3;
  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

  // Register indexes of the configuration port.
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam logic [7:0] PIX_MAX = 8'd255;

  // One result pixel with its coordinates.
  typedef struct packed {
    logic [7:0]     red;
    logic [7:0]     green;
    logic [7:0]     blue;
    logic [X_W-1:0] col;
    logic [Y_W-1:0] row;
    logic           last;
  } res_t;

  // Up to three results produced by one pixel, in stream order by slot.
  typedef struct packed {
    logic [MAX_RES-1:0]        valid;
    res_t [MAX_RES-1:0]        item;
  } res_wr_t;

  // Eight times the center minus the eight neighbors, clamped to 0..255.
  // Tap 4 is the center.
  function automatic logic [7:0] lap_chan(input logic [8:0][7:0] t);
    logic [11:0]        nsum;
    logic signed [12:0] acc;
    nsum = 12'd0;
    for (int i = 0; i < 9; i++) begin
      if (i != 4) nsum = nsum + {4'b0000, t[i]};
    end
    acc = $signed({2'b00, t[4], 3'b000}) - $signed({1'b0, nsum});
    if (acc < 0) begin
      return 8'd0;
    end else if (acc > $signed({5'b00000, PIX_MAX})) begin
      return PIX_MAX;
    end else begin
      return acc[7:0];
    end
  endfunction

endpackage

// ===== rtl/lef_line_ram.sv =====
// Simple dual-port RAM with a registered read, used for the two line stores.
// Stand-alone; no package needed.
module lef_line_ram #(
  parameter int ADDR_W = 10,
  parameter int DATA_W = 48
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/lef_result_fifo.sv =====
// Result queue: takes up to three results per cycle, hands out one per cycle when read.
// Depends on lef_pkg for the result types and queue sizes.
module lef_result_fifo
  import lef_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  res_wr_t               wr,
  output logic                  rd_valid,
  input  logic                  rd_ready,
  output res_t                  rd_item,
  output logic [FIFO_CNT_W-1:0] level
);

  res_t                  mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] count_r, count_nxt;
  logic [FIFO_PTR_W-1:0] waddr [MAX_RES];
  logic [FIFO_CNT_W-1:0] wr_num;
  logic                  pop;

  // Each valid slot lands after the valid slots ahead of it.
  always_comb begin
    logic [FIFO_CNT_W-1:0] off;
    off = '0;
    for (int k = 0; k < MAX_RES; k++) begin
      waddr[k] = wr_ptr_r + off[FIFO_PTR_W-1:0];
      off = off + FIFO_CNT_W'(wr.valid[k]);
    end
    wr_num = off;
  end

  assign pop        = rd_valid && rd_ready;
  assign wr_ptr_nxt = wr_ptr_r + wr_num[FIFO_PTR_W-1:0];
  assign rd_ptr_nxt = rd_ptr_r + FIFO_PTR_W'(pop);
  assign count_nxt  = count_r + wr_num - FIFO_CNT_W'(pop);

  // Storage; the producer reserves room, so writes never overrun.
  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_RES; k++) begin
      if (wr.valid[k]) mem[waddr[k]] <= wr.item[k];
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  assign rd_valid = (count_r != '0);
  assign rd_item  = mem[rd_ptr_r];
  assign level    = count_r;

endmodule

// ===== rtl/laplacian_edge_filter_3x3.sv =====
// Streaming 3x3 Laplacian edge filter on RGB pixels in raster order.
// Results of an accepted pixel pass through the input register and the result queue
// before they are offered. Throughput: one pixel per cycle while the queue has room;
// each pixel yields up to three results and the output moves one per cycle while
// out_tready is high, so row ends, the last row and output stalls pace the input.
// Reset clears counters, window and result queue and sets both sizes to 1024.
module laplacian_edge_filter_3x3
  import lef_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Pixel input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // in_red, in_green, in_blue
  // Result output channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // out_red, out_green, out_blue, out_col, out_row, zero fill
  output logic        out_tlast,  // frame_end
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [SIZE_W-1:0] width_r, height_r;
  logic [SIZE_W-1:0] w, h;
  logic              cfg_wr;

  logic [X_W-1:0]    col_r, col_nxt;
  logic [Y_W-1:0]    row_r, row_nxt;
  logic [X_W-1:0]    x_cur;
  logic [Y_W-1:0]    y_cur;
  logic              in_xfer;

  logic              s1_valid_r;
  logic [PIX_W-1:0]  s1_pix_r;
  logic [X_W-1:0]    s1_x_r;
  logic [Y_W-1:0]    s1_y_r;

  logic [2*PIX_W-1:0] line_rd;
  logic [PIX_W-1:0]   up, mid;
  logic [PIX_W-1:0]   win_r [6];

  logic [PIX_W-1:0]      lap;
  res_wr_t               fifo_wr;
  res_t                  head;
  logic [FIFO_CNT_W-1:0] fifo_level;
  logic [FIFO_CNT_W:0]   need;

  // Configuration registers; a write also restarts the frame.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SIZE_W'(MAX_WIDTH);
      height_r <= SIZE_W'(MAX_HEIGHT);
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_FRAME_WIDTH) width_r  <= cfg_pwdata[SIZE_W-1:0];
      else                                 height_r <= cfg_pwdata[SIZE_W-1:0];
    end
  end

  always_comb begin
    if (cfg_paddr[2] == REG_FRAME_WIDTH) cfg_prdata = {{(32-SIZE_W){1'b0}}, width_r};
    else                                 cfg_prdata = {{(32-SIZE_W){1'b0}}, height_r};
  end

  // Effective frame size, clamped to the supported range.
  always_comb begin
    if (width_r < SIZE_W'(2))              w = SIZE_W'(2);
    else if (width_r > SIZE_W'(MAX_WIDTH)) w = SIZE_W'(MAX_WIDTH);
    else                                   w = width_r;
    if (height_r < SIZE_W'(2))               h = SIZE_W'(2);
    else if (height_r > SIZE_W'(MAX_HEIGHT)) h = SIZE_W'(MAX_HEIGHT);
    else                                     h = height_r;
  end

  // Accept a pixel only when the queue has room for everything in flight.
  assign need      = {1'b0, fifo_level} + (s1_valid_r ? (FIFO_CNT_W+1)'(MAX_RES) : '0)
                     + (FIFO_CNT_W+1)'(MAX_RES);
  assign in_tready = (need <= (FIFO_CNT_W+1)'(FIFO_DEPTH));
  assign in_xfer   = in_tvalid && in_tready;

  // Raster position of the pixel now offered, and the position after it.
  always_comb begin
    logic [SIZE_W-1:0] x_inc, y_inc;
    if (({1'b0, col_r} >= w) || ({1'b0, row_r} >= h)) begin
      x_cur = '0;
      y_cur = '0;
    end else begin
      x_cur = col_r;
      y_cur = row_r;
    end
    x_inc = {1'b0, x_cur} + SIZE_W'(1);
    y_inc = {1'b0, y_cur} + SIZE_W'(1);
    if (x_inc >= w) begin
      col_nxt = '0;
      row_nxt = (y_inc >= h) ? '0 : y_inc[Y_W-1:0];
    end else begin
      col_nxt = x_inc[X_W-1:0];
      row_nxt = y_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cfg_wr) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_xfer) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Input register; the line stores are read at the same edge.
  always_ff @(posedge clk) begin
    if (!rst_n) s1_valid_r <= 1'b0;
    else        s1_valid_r <= in_xfer;
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_pix_r <= {in_tdata[7:0], in_tdata[15:8], in_tdata[23:16]};
      s1_x_r   <= x_cur;
      s1_y_r   <= y_cur;
    end
  end

  // Both line stores share one address: upper row high, middle row low.
  lef_line_ram #(
    .ADDR_W(X_W),
    .DATA_W(2*PIX_W)
  ) u_lines (
    .clk    (clk),
    .wr_en  (s1_valid_r),
    .wr_addr(s1_x_r),
    .wr_data({mid, s1_pix_r}),
    .rd_en  (in_xfer),
    .rd_addr(x_cur),
    .rd_data(line_rd)
  );

  assign up  = line_rd[2*PIX_W-1:PIX_W];
  assign mid = line_rd[PIX_W-1:0];

  // Two-column window shifts in the new column.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) win_r[i] <= '0;
    end else if (s1_valid_r) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= up;
      win_r[4] <= mid;
      win_r[5] <= s1_pix_r;
    end
  end

  // Laplacian for each channel over the nine taps.
  always_comb begin
    logic [8:0][PIX_W-1:0] taps;
    logic [8:0][7:0]       tp;
    taps[0] = win_r[0]; taps[1] = win_r[3]; taps[2] = up;
    taps[3] = win_r[1]; taps[4] = win_r[4]; taps[5] = mid;
    taps[6] = win_r[2]; taps[7] = win_r[5]; taps[8] = s1_pix_r;
    lap = '0;
    for (int ch = 0; ch < 3; ch++) begin
      for (int i = 0; i < 9; i++) tp[i] = taps[i][8*ch +: 8];
      lap[8*ch +: 8] = lap_chan(tp);
    end
  end

  // Results of the pixel in the input register, in stream order.
  always_comb begin
    logic [SIZE_W-1:0] wm1, hm1;
    logic [X_W-1:0]    cx;
    logic [Y_W-1:0]    cy;
    logic              interior;
    wm1      = w - SIZE_W'(1);
    hm1      = h - SIZE_W'(1);
    cx       = s1_x_r - X_W'(1);
    cy       = s1_y_r - Y_W'(1);
    interior = (cx != '0) && (cy != '0) && ({1'b0, cx} <= w - SIZE_W'(2));
    fifo_wr  = '0;

    // Center of the window, one row and one column back.
    fifo_wr.valid[0]      = s1_valid_r && (s1_y_r != '0) && (s1_x_r != '0);
    fifo_wr.item[0].red   = interior ? lap[23:16] : 8'd0;
    fifo_wr.item[0].green = interior ? lap[15:8]  : 8'd0;
    fifo_wr.item[0].blue  = interior ? lap[7:0]   : 8'd0;
    fifo_wr.item[0].col   = cx;
    fifo_wr.item[0].row   = cy;
    fifo_wr.item[0].last  = 1'b0;

    // Right border pixel of the row above, at the end of a row.
    fifo_wr.valid[1]    = s1_valid_r && (s1_y_r != '0) && ({1'b0, s1_x_r} == wm1);
    fifo_wr.item[1].col = wm1[X_W-1:0];
    fifo_wr.item[1].row = cy;

    // Bottom border pixel on the last row.
    fifo_wr.valid[2]     = s1_valid_r && ({1'b0, s1_y_r} == hm1);
    fifo_wr.item[2].col  = s1_x_r;
    fifo_wr.item[2].row  = s1_y_r;
    fifo_wr.item[2].last = ({1'b0, s1_x_r} == wm1);
  end

  lef_result_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (fifo_wr),
    .rd_valid(out_tvalid),
    .rd_ready(out_tready),
    .rd_item (head),
    .level   (fifo_level)
  );

  // Output transfer packing.
  assign out_tdata = {4'b0000, head.row, head.col, head.blue, head.green, head.red};
  assign out_tlast = head.last;

endmodule
